// ===== rtl/core/sach_pkg.sv =====
package sach_pkg;

	localparam logic [2:0] FN_LOAD    = 3'd0;
	localparam logic [2:0] FN_STORE   = 3'd1;
	localparam logic [2:0] FN_AGE     = 3'd2;
	localparam logic [2:0] FN_INSTALL = 3'd3;
	localparam logic [2:0] FN_FILL    = 3'd4;
	localparam logic [2:0] FN_META    = 3'd5;
	// Codes with no operation; such an item changes nothing and returns all zeros.
	localparam logic [2:0] FN_RSVD6   = 3'd6;
	localparam logic [2:0] FN_RSVD7   = 3'd7;

	localparam int TAG_W = 24;
	localparam int AGE_W = 16;

	localparam logic [AGE_W-1:0] AGE_MAX = 16'hFFFF;
	localparam logic [31:0] SEXT_HALF = 32'hFFFF0000;
	localparam logic [31:0] SEXT_BYTE = 32'hFFFFFF00;

	// Metadata of one way; a set row holds one of these per way.
	typedef struct packed {
		logic             valid;
		logic             dirty;
		logic [TAG_W-1:0] tag;
		logic [AGE_W-1:0] age;
	} way_t;

	// Byte operation handed to the line store for the data stage.
	typedef struct packed {
		logic        store;
		logic        fill;
		logic [7:0]  offset;
		logic [2:0]  size;
		logic        sext;
		logic [31:0] wdata;
		logic [3:0]  byte_idx;
	} data_op_t;

endpackage

// ===== rtl/core/sach_line_store.sv =====
module sach_line_store #(
	parameter int BLOCK_BYTES = 16,
	parameter int LINES = 64,
	localparam int LW = (LINES > 1) ? $clog2(LINES) : 1
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [LW-1:0]       rd_line,
	input  logic                wr_en,
	input  logic [LW-1:0]       wr_line,
	input  sach_pkg::data_op_t  op,
	output logic [31:0]         load_value
);

	typedef logic [BLOCK_BYTES-1:0][7:0] line_t;

	line_t mem [LINES];
	line_t rd_q;
	line_t wr_d;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_line];
		end
		if (wr_en) begin
			mem[wr_line] <= wr_d;
		end
	end

	// Bytes are big-endian: the first byte at the offset is the most significant.
	always_comb begin
		logic [31:0] pos;
		logic [31:0] v;
		logic [31:0] sh;
		wr_d = rd_q;
		v = '0;
		pos = '0;
		sh = '0;
		for (int j = 0; j < 4; j++) begin
			if (32'(j) < 32'(op.size)) begin
				pos = 32'(op.offset) + 32'(j);
				sh = 32'(8) * (32'(op.size) - 32'(1) - 32'(j));
				v = {v[23:0], 8'h00};
				for (int k = 0; k < BLOCK_BYTES; k++) begin
					if (32'(k) == pos) begin
						v[7:0] = rd_q[k];
						if (op.store) begin
							wr_d[k] = 8'(op.wdata >> sh);
						end
					end
				end
			end
		end
		for (int k = 0; k < BLOCK_BYTES; k++) begin
			if (op.fill && 32'(k) == 32'(op.byte_idx)) begin
				wr_d[k] = op.wdata[7:0];
			end
		end
		if (op.sext && op.size == 3'd2 && v[15]) begin
			v = v | sach_pkg::SEXT_HALF;
		end else if (op.sext && op.size == 3'd1 && v[7]) begin
			v = v | sach_pkg::SEXT_BYTE;
		end
		load_value = v;
	end

endmodule

// ===== rtl/core/set_assoc_cache_hit_path.sv =====
// Set-associative cache array with LRU ages, handling one item at a time. After
// acceptance an item passes the metadata state, then the data state: in the first,
// the set's metadata row, read from the metadata memory at acceptance, is compared
// and, on a hit, age or install, written back while the selected way's line is read
// from the line memory; in the second, the line is written back on a store hit or
// fill and the result is registered, once the output register is free. The input is
// accepted again in the cycle after the result is registered, while that result may
// still wait at the output. After reset a clearing pass writes zero to every metadata
// row, one row a cycle, with the input held off.
// BLOCK_BYTES and SETS must be powers of two. Line bytes are undefined until
// filled or stored.
module set_assoc_cache_hit_path #(
	parameter int BLOCK_BYTES = 16,
	parameter int SETS = 16,
	parameter int WAYS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [31:0] address,
	input  logic [2:0]  access_size,
	input  logic        sign_extend,
	input  logic [31:0] write_data,
	input  logic [3:0]  set_index,
	input  logic [1:0]  way_index,
	input  logic [3:0]  byte_index,
	input  logic [23:0] fill_tag,
	input  logic        fill_valid,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [31:0] read_data,
	output logic        fault,
	output logic        line_valid,
	output logic        line_dirty,
	output logic [23:0] line_tag,
	output logic [15:0] line_age
);

	localparam int OB = $clog2(BLOCK_BYTES);
	localparam int SB = $clog2(SETS);
	localparam int SW = (SETS > 1) ? SB : 1;
	localparam int LINES = SETS * WAYS;
	localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_META = 2'd2;
	localparam logic [1:0] ST_DATA = 2'd3;

	typedef sach_pkg::way_t [WAYS-1:0] row_t;

	logic [1:0] state_q;
	logic [SW-1:0] clr_q;
	logic out_valid_q;

	logic [2:0] func_q;
	logic [31:0] address_q;
	logic [2:0] access_size_q;
	logic sign_extend_q;
	logic [31:0] write_data_q;
	logic [1:0] way_index_q;
	logic [3:0] byte_index_q;
	logic [23:0] fill_tag_q;
	logic fill_valid_q;
	logic sel_ok_q;
	logic [SW-1:0] set_q;

	row_t meta_mem [SETS];
	row_t meta_rd_s1;
	row_t meta_wd;
	logic meta_we;
	logic [SW-1:0] meta_wa;
	logic [SW-1:0] rd_set;
	logic accept;

	logic hit_d, fault_d, fill_ok_d;
	logic [LW-1:0] line_d;
	sach_pkg::data_op_t op_d;
	sach_pkg::way_t meta_out_d;

	logic hit_s2, fault_s2, load_s2, wr_s2;
	logic [LW-1:0] line_s2;
	sach_pkg::data_op_t op_s2;
	sach_pkg::way_t meta_out_s2;

	logic advance;
	logic [31:0] load_value;

	logic hit_q, fault_q;
	logic [31:0] read_data_q;
	sach_pkg::way_t meta_out_q;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign advance = (state_q == ST_DATA) && (!out_valid_q || out_ready);

	always_comb begin
		if (func == sach_pkg::FN_INSTALL || func == sach_pkg::FN_FILL
				|| func == sach_pkg::FN_META) begin
			rd_set = SW'(set_index);
		end else if (SETS > 1) begin
			rd_set = SW'(address >> OB);
		end else begin
			rd_set = '0;
		end
	end

	// Metadata row processing in the cycle after the row read.
	always_comb begin
		logic [31:0] off;
		logic [31:0] size;
		logic [31:0] tag32;
		logic [31:0] way_sel;
		logic ls;
		logic any;
		off = 32'(address_q) & 32'(BLOCK_BYTES - 1);
		size = (access_size_q == 3'd4) ? 32'd4 : (access_size_q == 3'd2) ? 32'd2 : 32'd1;
		tag32 = address_q >> (OB + SB);
		ls = (func_q == sach_pkg::FN_LOAD) || (func_q == sach_pkg::FN_STORE);
		fault_d = ls && (off + size > 32'(BLOCK_BYTES));
		any = 1'b0;
		way_sel = 32'(way_index_q);
		// The lowest matching way wins.
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (meta_rd_s1[w].valid && tag32 == {8'h00, meta_rd_s1[w].tag}) begin
				any = 1'b1;
				if (ls) begin
					way_sel = 32'(w);
				end
			end
		end
		hit_d = ls && any && !fault_d;
		fill_ok_d = (func_q == sach_pkg::FN_FILL) && sel_ok_q
			&& (32'(byte_index_q) < 32'(BLOCK_BYTES));
		line_d = LW'(32'(set_q) * 32'(WAYS) + way_sel);

		meta_wd = meta_rd_s1;
		meta_out_d = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (hit_d && 32'(w) == way_sel) begin
				meta_wd[w].age = '0;
				if (func_q == sach_pkg::FN_STORE) begin
					meta_wd[w].dirty = 1'b1;
				end
			end
			if (func_q == sach_pkg::FN_AGE && meta_rd_s1[w].valid
					&& meta_rd_s1[w].age != sach_pkg::AGE_MAX) begin
				meta_wd[w].age = meta_rd_s1[w].age + 16'd1;
			end
			if (func_q == sach_pkg::FN_INSTALL && sel_ok_q && 32'(w) == way_sel) begin
				meta_wd[w].valid = fill_valid_q;
				meta_wd[w].dirty = 1'b0;
				meta_wd[w].tag = fill_tag_q;
				meta_wd[w].age = '0;
			end
			if (func_q == sach_pkg::FN_META && sel_ok_q && 32'(w) == way_sel) begin
				meta_out_d = meta_rd_s1[w];
			end
		end

		op_d.store = (func_q == sach_pkg::FN_STORE);
		op_d.fill = (func_q == sach_pkg::FN_FILL);
		op_d.offset = 8'(off);
		op_d.size = 3'(size);
		op_d.sext = sign_extend_q;
		op_d.wdata = write_data_q;
		op_d.byte_idx = byte_index_q;

		if (state_q == ST_CLR) begin
			meta_we = 1'b1;
			meta_wa = clr_q;
		end else begin
			meta_we = (state_q == ST_META) && (hit_d || func_q == sach_pkg::FN_AGE
				|| (func_q == sach_pkg::FN_INSTALL && sel_ok_q));
			meta_wa = set_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_rd_s1 <= meta_mem[rd_set];
		end
		if (meta_we) begin
			meta_mem[meta_wa] <= (state_q == ST_CLR) ? row_t'('0) : meta_wd;
		end
	end

	sach_line_store #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.LINES(LINES)
	) u_lines (
		.clk(clk),
		.rd_en(state_q == ST_META),
		.rd_line(line_d),
		.wr_en(advance && wr_s2),
		.wr_line(line_s2),
		.op(op_s2),
		.load_value(load_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == 32'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_META;
					end
				end
				ST_META: begin
					state_q <= ST_DATA;
				end
				ST_DATA: begin
					if (advance) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			address_q <= address;
			access_size_q <= access_size;
			sign_extend_q <= sign_extend;
			write_data_q <= write_data;
			way_index_q <= way_index;
			byte_index_q <= byte_index;
			fill_tag_q <= fill_tag;
			fill_valid_q <= fill_valid;
			sel_ok_q <= (32'(set_index) < 32'(SETS)) && (32'(way_index) < 32'(WAYS));
			set_q <= rd_set;
		end
		if (state_q == ST_META) begin
			hit_s2 <= hit_d;
			fault_s2 <= fault_d;
			load_s2 <= (func_q == sach_pkg::FN_LOAD);
			wr_s2 <= (hit_d && func_q == sach_pkg::FN_STORE) || fill_ok_d;
			line_s2 <= line_d;
			op_s2 <= op_d;
			meta_out_s2 <= meta_out_d;
		end
		if (advance) begin
			hit_q <= hit_s2;
			fault_q <= fault_s2;
			read_data_q <= (hit_s2 && load_s2) ? load_value : 32'd0;
			meta_out_q <= meta_out_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign fault = fault_q;
	assign read_data = read_data_q;
	assign line_valid = meta_out_q.valid;
	assign line_dirty = meta_out_q.dirty;
	assign line_tag = meta_out_q.tag;
	assign line_age = meta_out_q.age;

`ifndef SYNTHESIS
	a_fault_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(fault && hit))
		else $error("fault and hit reported together");
	a_data_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && read_data != 32'd0) |-> hit)
		else $error("read data without a hit");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while one is in flight");
`endif

endmodule

// ===== test/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLK = 16;
	localparam int NSETS = 16;
	localparam int NWAYS = 4;
	localparam int IDLE_LIMIT = 4000;

	typedef struct packed {
		logic [2:0]  fn;
		logic [31:0] addr;
		logic [2:0]  asz;
		logic        sext;
		logic [31:0] wdata;
		logic [3:0]  sidx;
		logic [1:0]  widx;
		logic [3:0]  bidx;
		logic [23:0] ftag;
		logic        fvalid;
	} access_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] rdata;
		logic        fault;
		logic        lvalid;
		logic        ldirty;
		logic [23:0] ltag;
		logic [15:0] lage;
	} answer_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [2:0] func = 0;
	logic [31:0] address = 0;
	logic [2:0] access_size = 1;
	logic sign_extend = 0;
	logic [31:0] write_data = 0;
	logic [3:0] set_index = 0;
	logic [1:0] way_index = 0;
	logic [3:0] byte_index = 0;
	logic [23:0] fill_tag = 0;
	logic fill_valid = 0;
	logic out_valid;
	logic out_ready = 0;
	logic hit;
	logic [31:0] read_data;
	logic fault;
	logic line_valid;
	logic line_dirty;
	logic [23:0] line_tag;
	logic [15:0] line_age;

	set_assoc_cache_hit_path dut (.*);

	always #6 clk = ~clk;

	// Shadow copy of the cache array.
	logic        sh_valid [NSETS*NWAYS];
	logic        sh_dirty [NSETS*NWAYS];
	logic [23:0] sh_tag [NSETS*NWAYS];
	logic [15:0] sh_age [NSETS*NWAYS];
	logic [7:0]  sh_bytes [NSETS*NWAYS*BLK];
	logic        sh_written [NSETS*NWAYS*BLK];

	answer_t pending_answers[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int out_idle_pct = 35;
	int hold_off = 0;
	int in_idle_pct = 35;

	function automatic int lookup(logic [31:0] a);
		int s;
		logic [27:0] t;
		s = (a / BLK) % NSETS;
		t = 28'(a / BLK / NSETS);
		for (int w = 0; w < NWAYS; w++)
			if (sh_valid[s*NWAYS+w] && t[27:24] == 4'd0 && sh_tag[s*NWAYS+w] == t[23:0])
				return s*NWAYS + w;
		return -1;
	endfunction

	function automatic answer_t cache_apply(access_t x);
		answer_t r;
		int off, sz, ln, s, sel;
		logic [31:0] v;
		r = '0;
		off = x.addr % BLK;
		sz = (x.asz == 3'd4) ? 4 : (x.asz == 3'd2) ? 2 : 1;
		sel = x.sidx * NWAYS + x.widx;
		case (x.fn)
			sach_pkg::FN_LOAD, sach_pkg::FN_STORE: begin
				if (off + sz > BLK) begin
					r.fault = 1'b1;
				end else begin
					ln = lookup(x.addr);
					if (ln >= 0) begin
						r.hit = 1'b1;
						sh_age[ln] = '0;
						if (x.fn == sach_pkg::FN_LOAD) begin
							v = '0;
							for (int j = 0; j < sz; j++)
								v = (v << 8) | 32'(sh_bytes[ln*BLK+off+j]);
							if (x.sext && sz == 2 && v[15]) v |= sach_pkg::SEXT_HALF;
							else if (x.sext && sz == 1 && v[7]) v |= sach_pkg::SEXT_BYTE;
							r.rdata = v;
						end else begin
							sh_dirty[ln] = 1'b1;
							for (int j = 0; j < sz; j++) begin
								sh_bytes[ln*BLK+off+j] = 8'(x.wdata >> (8*(sz-1-j)));
								sh_written[ln*BLK+off+j] = 1'b1;
							end
						end
					end
				end
			end
			sach_pkg::FN_AGE: begin
				s = (x.addr / BLK) % NSETS;
				for (int w = 0; w < NWAYS; w++)
					if (sh_valid[s*NWAYS+w] && sh_age[s*NWAYS+w] != sach_pkg::AGE_MAX)
						sh_age[s*NWAYS+w]++;
			end
			sach_pkg::FN_INSTALL: begin
				sh_valid[sel] = x.fvalid;
				sh_tag[sel] = x.ftag;
				sh_dirty[sel] = 1'b0;
				sh_age[sel] = '0;
			end
			sach_pkg::FN_FILL: begin
				sh_bytes[sel*BLK+x.bidx] = x.wdata[7:0];
				sh_written[sel*BLK+x.bidx] = 1'b1;
			end
			sach_pkg::FN_META: begin
				r.lvalid = sh_valid[sel];
				r.ldirty = sh_dirty[sel];
				r.ltag = sh_tag[sel];
				r.lage = sh_age[sel];
			end
			default: ;
		endcase
		return r;
	endfunction

	// A load hit must never touch a byte that was never written.
	function automatic bit load_safe(access_t x);
		int off, sz, ln;
		if (x.fn != sach_pkg::FN_LOAD) return 1'b1;
		off = x.addr % BLK;
		sz = (x.asz == 3'd4) ? 4 : (x.asz == 3'd2) ? 2 : 1;
		if (off + sz > BLK) return 1'b1;
		ln = lookup(x.addr);
		if (ln < 0) return 1'b1;
		for (int j = 0; j < sz; j++)
			if (!sh_written[ln*BLK+off+j]) return 1'b0;
		return 1'b1;
	endfunction

	// Valid stays high from one item to the next unless the sender idles.
	task automatic send_access(access_t x);
		if (!load_safe(x)) return;
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		in_valid <= 1'b1;
		func <= x.fn;
		address <= x.addr;
		access_size <= x.asz;
		sign_extend <= x.sext;
		write_data <= x.wdata;
		set_index <= x.sidx;
		way_index <= x.widx;
		byte_index <= x.bidx;
		fill_tag <= x.ftag;
		fill_valid <= x.fvalid;
		do @(posedge clk); while (!in_ready);
		pending_answers.push_back(cache_apply(x));
	endtask

	function automatic access_t rand_access();
		access_t x;
		x.fn = 3'($urandom_range(7));
		x.addr = $urandom;
		x.asz = 3'($urandom_range(7));
		x.sext = 1'($urandom);
		x.wdata = $urandom;
		x.sidx = 4'($urandom);
		x.widx = 2'($urandom);
		x.bidx = 4'($urandom);
		x.ftag = 24'($urandom);
		x.fvalid = 1'($urandom);
		return x;
	endfunction

	// Address that lands in a line, from a small tag pool so hits are common.
	function automatic logic [31:0] make_addr(logic [23:0] t, int s, int off);
		return {t, 8'(s * BLK + off)};
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_directed();
		access_t x;
		x = '0;
		// Install a line with an all-ones tag and fill it completely.
		x.fn = sach_pkg::FN_INSTALL; x.sidx = 4'd15; x.widx = 2'd3;
		x.ftag = 24'hFFFFFF; x.fvalid = 1'b1;
		send_access(x);
		for (int b = 0; b < BLK; b++) begin
			x.fn = sach_pkg::FN_FILL; x.bidx = 4'(b);
			x.wdata = 32'h0000_0080 + 32'(b) * 32'd17;
			send_access(x);
		end
		x = '0; x.fn = sach_pkg::FN_LOAD; x.addr = 32'hFFFF_FFFC; x.asz = 3'd4; send_access(x);
		x.addr = 32'hFFFF_FFFE; x.asz = 3'd2; x.sext = 1'b1; send_access(x);
		x.addr = 32'hFFFF_FFF0; x.asz = 3'd0; send_access(x);
		x.addr = 32'hFFFF_FFFF; x.asz = 3'd2; send_access(x);
		x.fn = sach_pkg::FN_STORE; x.addr = 32'hFFFF_FFF1; x.asz = 3'd4;
		x.wdata = 32'hDEADBEEF;
		send_access(x);
		x.fn = sach_pkg::FN_AGE; send_access(x);
		x.fn = sach_pkg::FN_META; x.sidx = 4'd15; x.widx = 2'd3; send_access(x);
		x.fn = sach_pkg::FN_RSVD6; send_access(x);
		x.fn = sach_pkg::FN_RSVD7; send_access(x);
		x.fn = sach_pkg::FN_LOAD; x.addr = 32'h0; x.asz = 3'd1; send_access(x);
	endtask

	task automatic test_age_burst();
		access_t x;
		x = '0;
		x.fn = sach_pkg::FN_INSTALL; x.sidx = 4'd2; x.widx = 2'd1;
		x.ftag = 24'h5; x.fvalid = 1'b1;
		send_access(x);
		in_idle_pct = 0;
		out_idle_pct = 0;
		x.fn = sach_pkg::FN_AGE; x.addr = make_addr(24'h0, 2, 0);
		repeat (40) send_access(x);
		in_idle_pct = 35;
		out_idle_pct = 35;
		x.fn = sach_pkg::FN_META; send_access(x);
	endtask

	task automatic test_random(int n);
		access_t x;
		int s, w;
		for (int i = 0; i < n; i++) begin
			if (i == n / 3) begin
				hold_off = 300;
			end
			if (i == n / 2) wait_drained();
			if (i > n / 4 && i < n / 4 + 150) begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end else if (i >= n / 4 + 150) begin
				in_idle_pct = 35;
				out_idle_pct = 35;
			end
			x = rand_access();
			s = $urandom_range(NSETS - 1);
			w = $urandom_range(NWAYS - 1);
			case ($urandom_range(9))
				0, 1, 2: begin
					x.fn = ($urandom_range(1) != 0) ? sach_pkg::FN_STORE : sach_pkg::FN_LOAD;
					x.addr = make_addr(24'($urandom_range(3)), s, $urandom_range(BLK - 1));
					x.asz = $urandom_range(2) == 0 ? 3'd4 : $urandom_range(2) == 0 ? 3'd2 : 3'(x.asz);
				end
				3: begin
					x.fn = sach_pkg::FN_INSTALL;
					x.ftag = 24'($urandom_range(3));
					x.fvalid = $urandom_range(5) != 0;
				end
				4, 5: begin
					// Fill a whole line so later loads stay defined.
					for (int b = 0; b < BLK; b++) begin
						x.fn = sach_pkg::FN_FILL; x.sidx = 4'(s); x.widx = 2'(w); x.bidx = 4'(b);
						x.wdata = $urandom;
						send_access(x);
					end
					x.fn = sach_pkg::FN_META;
				end
				6: begin
					x.fn = sach_pkg::FN_AGE;
					x.addr = make_addr(24'($urandom_range(3)), s, 0);
				end
				7: x.fn = sach_pkg::FN_META;
				default: ;
			endcase
			send_access(x);
		end
	endtask

	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= $urandom_range(99) >= out_idle_pct;
		end
	end

	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{hit, read_data, fault, line_valid, line_dirty, line_tag, line_age};
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				want = pending_answers.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NSETS*NWAYS; i++) begin
			sh_valid[i] = 1'b0; sh_dirty[i] = 1'b0; sh_tag[i] = '0; sh_age[i] = '0;
		end
		for (int i = 0; i < NSETS*NWAYS*BLK; i++) begin
			sh_bytes[i] = '0; sh_written[i] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(430);
		test_age_burst();
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
